@@ rtl/longest_palindrome_dp_finder_defines.svh @@
// Assertion macros shared by the checker.
`ifndef LONGEST_PALINDROME_DP_FINDER_DEFINES_SVH
`define LONGEST_PALINDROME_DP_FINDER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define LPDF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lpdf: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define LPDF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lpdf: next-cycle check failed");

`endif

@@ rtl/lpdf_pkg.sv @@
package lpdf_pkg;

    // Default string capacity in bytes
    localparam int unsigned MAX_LEN_DEF = 64;

    // Input word: one byte of the string
    typedef struct packed {
        logic [7:0] char_byte;
        logic       is_last;
    } t_in_word;

    // Output word: first longest palindrome of the string
    typedef struct packed {
        logic [5:0] best_start;
        logic [6:0] best_length;
        logic       overflow;
    } t_out_word;

    // Controller states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

@@ rtl/longest_palindrome_dp_finder.sv @@
// Throughput: bytes load one per cycle while o_in_stall is low, and no byte is taken during
// the search; the search visits one table cell per cycle, set by the single write port of the
// palindrome table memory.
// The next string may load while the previous result waits to be taken.
// Reset: synchronous, active low; clears control state only, the text and table memories
// are not cleared and every entry is written before it is read.
module longest_palindrome_dp_finder #(
    parameter int unsigned MAX_LEN = lpdf_pkg::MAX_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lpdf_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lpdf_pkg::t_out_word o_out_word
);

    localparam int unsigned IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned CW = $clog2(MAX_LEN + 1);

    // Storage: text bytes and palindrome flags, two banks by length parity
    logic [7:0] text_mem [MAX_LEN];
    logic       palin_mem [2**(IW+1)];

    lpdf_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [CW-1:0] r_len;
    logic [IW-1:0] r_idx;

    logic          r_s1_vld;
    logic [CW-1:0] r_s1_len;
    logic [IW-1:0] r_s1_idx;
    logic [7:0]    r_ch_i;
    logic [7:0]    r_ch_j;
    logic          r_pal_rd;

    logic [IW-1:0] r_best_start;
    logic [CW-1:0] r_best_len;

    logic                r_out_vld;
    lpdf_pkg::t_out_word r_out;

    logic          w_in_acc;
    logic          w_issue;
    logic          w_out_load;
    logic [CW-1:0] w_end;
    logic          w_row_last;
    logic          w_last_row;
    logic [IW-1:0] w_pal_idx;
    logic          w_pal;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_end      = CW'(r_idx) + r_len - CW'(1);
    assign w_row_last = (CW'(r_idx) + r_len) == r_count;
    assign w_last_row = r_len == r_count;
    assign w_pal_idx  = (r_len > CW'(2)) ? IW'(r_idx + IW'(1)) : '0;

    // Evaluate one cell from the registered memory reads
    assign w_pal = (r_s1_len == CW'(1)) ||
                   ((r_ch_i == r_ch_j) && ((r_s1_len == CW'(2)) || r_pal_rd));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lpdf_pkg::ST_LOAD: begin
                if (w_in_acc && i_in_word.is_last) begin
                    n_state = lpdf_pkg::ST_SEARCH;
                end
            end
            lpdf_pkg::ST_SEARCH: begin
                if (w_row_last && w_last_row) begin
                    n_state = lpdf_pkg::ST_DRAIN;
                end
            end
            lpdf_pkg::ST_DRAIN: begin
                n_state = lpdf_pkg::ST_FINISH;
            end
            lpdf_pkg::ST_FINISH: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_state = lpdf_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = lpdf_pkg::ST_LOAD;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_issue    = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            lpdf_pkg::ST_LOAD: begin
                o_in_stall = 1'b0;
            end
            lpdf_pkg::ST_SEARCH: begin
                w_issue = 1'b1;
            end
            lpdf_pkg::ST_DRAIN: begin
                w_issue = 1'b0;
            end
            lpdf_pkg::ST_FINISH: begin
                w_out_load = !r_out_vld || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Text memory: write on load, two registered reads for the cell ends
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (r_count < CW'(MAX_LEN))) begin
            text_mem[r_count[IW-1:0]] <= i_in_word.char_byte;
        end
        r_ch_i <= text_mem[r_idx];
        r_ch_j <= text_mem[w_end[IW-1:0]];
    end

    // Palindrome table: read the inner cell, write back the evaluated one
    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            palin_mem[{r_s1_len[0], r_s1_idx}] <= w_pal;
        end
        r_pal_rd <= palin_mem[{r_len[0], w_pal_idx}];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lpdf_pkg::ST_LOAD;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_len     <= '0;
            r_idx     <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= w_issue;

            // Count bytes, flag drops past capacity
            if (w_in_acc) begin
                if (r_count < CW'(MAX_LEN)) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end

            // Start the walk at length one, advance by start, then by length
            if (w_in_acc && i_in_word.is_last) begin
                r_len <= CW'(1);
                r_idx <= '0;
            end else if (w_issue) begin
                if (w_row_last) begin
                    r_len <= r_len + CW'(1);
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end

            // Hand the result over and clear for the next string
            if (w_out_load) begin
                r_out_vld <= 1'b1;
                r_count   <= '0;
                r_ovf     <= 1'b0;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Pipeline and result payload
    always_ff @(posedge i_clk) begin
        r_s1_len <= r_len;
        r_s1_idx <= r_idx;

        if (w_in_acc && i_in_word.is_last) begin
            r_best_start <= '0;
            r_best_len   <= CW'(1);
        end else if (r_s1_vld && w_pal && (r_s1_len > r_best_len)) begin
            r_best_start <= r_s1_idx;
            r_best_len   <= r_s1_len;
        end

        if (w_out_load) begin
            r_out.best_start  <= 6'(r_best_start);
            r_out.best_length <= 7'(r_best_len);
            r_out.overflow    <= r_ovf;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

@@ rtl/lpdf_checker.sv @@
`include "longest_palindrome_dp_finder_defines.svh"

module lpdf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input lpdf_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lpdf_pkg::t_out_word o_out_word
);

    logic w_last_acc;

    assign w_last_acc = i_in_valid && !o_in_stall && i_in_word.is_last;

    // Hold a stalled result word
    `LPDF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `LPDF_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_word))
    // A result is never empty
    `LPDF_ASSERT_SAME(a_len_nonzero, o_out_valid, o_out_word.best_length != 7'd0)
    // Stall input while the search runs
    `LPDF_ASSERT_NEXT(a_search_stall, w_last_acc, o_in_stall)
    // No result appears right after the closing byte
    `LPDF_ASSERT_NEXT(a_no_early_result, w_last_acc, !$rose(o_out_valid))

endmodule

bind longest_palindrome_dp_finder lpdf_checker u_lpdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

@@ tb/testbench.sv @@
module testbench;

    localparam int unsigned STR_CAP      = lpdf_pkg::MAX_LEN_DEF;
    localparam int unsigned RANDOM_ITEMS = 950;
    localparam int unsigned HOLD_CYCLES  = 2000;
    localparam int unsigned HOLD_AFTER   = 40;
    localparam int unsigned DIR_ROWS     = 25;
    localparam int unsigned REPORT_MAX   = 10;

    // One directed row: a byte sent reps times, the end flag on the last copy
    typedef struct packed {
        logic [7:0]          ch;
        logic                last;
        logic [6:0]          reps;
        logic                typed;
        lpdf_pkg::t_out_word want;
    } t_stim_row;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    lpdf_pkg::t_in_word  in_word;
    logic                out_valid;
    logic                out_stall;
    lpdf_pkg::t_out_word out_word;

    // Shadow of the string being loaded
    logic [7:0]  text_copy [STR_CAP];
    int unsigned held_count;
    bit          trunc_seen;

    lpdf_pkg::t_out_word pending_results [$];
    t_stim_row           dir_rows [DIR_ROWS];
    int unsigned         fail_cnt;
    int unsigned         results_seen;
    bit                  send_calm;
    bit                  recv_calm;

    longest_palindrome_dp_finder dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("longest_palindrome_dp_finder verification failed");
        $finish;
    end

    // Absorb one byte; on the end flag, search the held string and clear it
    function automatic bit take_byte(input lpdf_pkg::t_in_word w,
                                     output lpdf_pkg::t_out_word res);
        bit          pal [STR_CAP][STR_CAP];
        bit          ok;
        int unsigned span;
        int unsigned lo;
        int unsigned hi;
        int unsigned best_at;
        int unsigned best_len;
        res = '0;
        if (held_count < STR_CAP) begin
            text_copy[held_count] = w.char_byte;
            held_count++;
        end else begin
            trunc_seen = 1'b1;
        end
        if (!w.is_last)
            return 1'b0;
        best_at  = 0;
        best_len = 1;
        // fill the table by growing span, keep the earliest longest hit
        for (span = 1; span <= held_count; span++) begin
            for (lo = 0; lo + span <= held_count; lo++) begin
                hi = lo + span - 1;
                if (span == 1)
                    ok = 1'b1;
                else if (span == 2)
                    ok = (text_copy[lo] == text_copy[hi]);
                else
                    ok = pal[lo + 1][hi - 1] && (text_copy[lo] == text_copy[hi]);
                pal[lo][hi] = ok;
                if (ok && span > best_len) begin
                    best_at  = lo;
                    best_len = span;
                end
            end
        end
        res.best_start  = best_at[5:0];
        res.best_length = best_len[6:0];
        res.overflow    = trunc_seen;
        held_count = 0;
        trunc_seen = 1'b0;
        return 1'b1;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one word, wait for it to be taken, then record what it should produce
    task automatic drive_word(input lpdf_pkg::t_in_word w, input bit use_typed,
                              input lpdf_pkg::t_out_word typed_res);
        int                  gap;
        lpdf_pkg::t_out_word res;
        gap = send_calm ? 0 : pick_idle();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (take_byte(w, res))
            pending_results.push_back(use_typed ? typed_res : res);
    endtask

    // Stimulus: reset, directed table, then random strings
    initial begin
        lpdf_pkg::t_in_word w;
        logic [7:0]  str_buf [0:127];
        logic [7:0]  sym [0:2];
        int unsigned sent_random;
        int unsigned len;
        int unsigned plen;
        int unsigned pos;
        int unsigned nsym;
        int          r;
        int          mode;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        held_count = 0;
        trunc_seen = 1'b0;
        fail_cnt   = 0;
        send_calm  = 1'b0;

        // single bytes, two bytes, short palindromes, full and overfull strings
        dir_rows[0]  = '{8'h00, 1'b1, 7'd1,  1'b1, '{6'd0, 7'd1,  1'b0}};
        dir_rows[1]  = '{8'hFF, 1'b1, 7'd1,  1'b1, '{6'd0, 7'd1,  1'b0}};
        dir_rows[2]  = '{8'h00, 1'b0, 7'd1,  1'b0, '0};
        dir_rows[3]  = '{8'hFF, 1'b1, 7'd1,  1'b1, '{6'd0, 7'd1,  1'b0}};
        dir_rows[4]  = '{8'h5A, 1'b0, 7'd1,  1'b0, '0};
        dir_rows[5]  = '{8'h5A, 1'b1, 7'd1,  1'b1, '{6'd0, 7'd2,  1'b0}};
        dir_rows[6]  = '{8'h63, 1'b0, 7'd1,  1'b0, '0};
        dir_rows[7]  = '{8'h61, 1'b0, 7'd1,  1'b0, '0};
        dir_rows[8]  = '{8'h62, 1'b0, 7'd1,  1'b0, '0};
        dir_rows[9]  = '{8'h61, 1'b1, 7'd1,  1'b0, '0};
        dir_rows[10] = '{8'h61, 1'b0, 7'd1,  1'b0, '0};
        dir_rows[11] = '{8'h62, 1'b0, 7'd1,  1'b0, '0};
        dir_rows[12] = '{8'h62, 1'b0, 7'd1,  1'b0, '0};
        dir_rows[13] = '{8'h61, 1'b0, 7'd1,  1'b0, '0};
        dir_rows[14] = '{8'h78, 1'b1, 7'd1,  1'b0, '0};
        dir_rows[15] = '{8'h01, 1'b0, 7'd1,  1'b0, '0};
        dir_rows[16] = '{8'h02, 1'b0, 7'd1,  1'b0, '0};
        dir_rows[17] = '{8'h01, 1'b0, 7'd1,  1'b0, '0};
        dir_rows[18] = '{8'h03, 1'b0, 7'd1,  1'b0, '0};
        dir_rows[19] = '{8'h04, 1'b0, 7'd1,  1'b0, '0};
        dir_rows[20] = '{8'h03, 1'b1, 7'd1,  1'b0, '0};
        dir_rows[21] = '{8'hA5, 1'b1, 7'd64, 1'b1, '{6'd0, 7'd64, 1'b0}};
        dir_rows[22] = '{8'h3C, 1'b0, 7'd65, 1'b0, '0};
        dir_rows[23] = '{8'hC3, 1'b1, 7'd1,  1'b1, '{6'd0, 7'd64, 1'b1}};
        dir_rows[24] = '{8'h80, 1'b1, 7'd1,  1'b1, '{6'd0, 7'd1,  1'b0}};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // walk the directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            for (int k = 1; k <= dir_rows[i].reps; k++) begin
                w.char_byte = dir_rows[i].ch;
                w.is_last   = dir_rows[i].last && (k == dir_rows[i].reps);
                drive_word(w, dir_rows[i].typed && w.is_last, dir_rows[i].want);
            end
        end

        // random strings: few symbols, embedded palindromes, or plain noise
        sent_random = 0;
        while (sent_random < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 78)
                len = $urandom_range(1, 12);
            else if (r < 90)
                len = $urandom_range(13, 40);
            else if (r < 96)
                len = $urandom_range(58, 64);
            else
                len = $urandom_range(65, 72);
            mode = $urandom_range(0, 9);
            if (mode < 4) begin
                nsym = $urandom_range(2, 3);
                for (int k = 0; k < 3; k++) sym[k] = 8'($urandom);
                for (int k = 0; k < len; k++) str_buf[k] = sym[$urandom_range(0, nsym - 1)];
            end else begin
                for (int k = 0; k < len; k++) str_buf[k] = 8'($urandom);
                if (mode < 8 && len > 1) begin
                    plen = $urandom_range(2, (len > STR_CAP) ? STR_CAP : len);
                    pos  = $urandom_range(0, ((len > STR_CAP) ? STR_CAP : len) - plen);
                    for (int k = 0; k < plen / 2; k++)
                        str_buf[pos + plen - 1 - k] = str_buf[pos + k];
                end
            end
            send_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len; k++) begin
                w.char_byte = str_buf[k];
                w.is_last   = (k == len - 1);
                drive_word(w, 1'b0, '0);
            end
            sent_random += len;
        end
        in_valid <= 1'b0;

        // drain outstanding results, then settle
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_cnt == 0)
            $display("longest_palindrome_dp_finder verification clean");
        else
            $display("longest_palindrome_dp_finder verification failed");
        $finish;
    end

    // Result side: random stall runs, one long hold, check each accepted word
    initial begin
        lpdf_pkg::t_out_word want;
        int unsigned stall_left;
        int unsigned calm_timer;
        bit          held;

        out_stall    = 1'b0;
        results_seen = 0;
        stall_left   = 0;
        calm_timer   = 0;
        held         = 1'b0;
        recv_calm    = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display("unexpected result word: start %0d length %0d overflow %0b",
                                 out_word.best_start, out_word.best_length, out_word.overflow);
                end else begin
                    want = pending_results.pop_front();
                    if (out_word.best_start !== want.best_start ||
                        out_word.best_length !== want.best_length ||
                        out_word.overflow !== want.overflow) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX)
                            $display({"result mismatch: expected start %0d length %0d ",
                                      "ovf %0b, got start %0d length %0d ovf %0b"},
                                     want.best_start, want.best_length, want.overflow,
                                     out_word.best_start, out_word.best_length,
                                     out_word.overflow);
                    end
                end
            end
            // switch between calm and busy stretches now and then
            calm_timer++;
            if (calm_timer >= 300) begin
                calm_timer = 0;
                recv_calm  = ($urandom_range(0, 3) == 0);
            end
            if (!held && results_seen >= HOLD_AFTER) begin
                // hold off long enough for the block to back up its input
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                if (!recv_calm && $urandom_range(0, 3) == 0)
                    stall_left = pick_idle();
            end
        end
    end

endmodule
